[hdl/rgp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared widths, register indexes, mode codes and types of the gradient
// projection pipeline.
// ----------------------------------------------------------------------------
package rgp_pkg;

  localparam int COORD_BITS     = 12;
  localparam int GRAD_FRAC_BITS = 8;
  localparam int GRAD_BITS      = COORD_BITS + GRAD_FRAC_BITS;
  localparam int REF_BITS       = 17;
  localparam int REF_FRAC       = 4;
  localparam int TRIG_FRAC      = 15;
  localparam int TRIG_W         = TRIG_FRAC + 1;
  localparam int VALUE_W        = 44;

  localparam int POS_W  = COORD_BITS + REF_FRAC;
  localparam int DX_W   = ((POS_W > REF_BITS - 1) ? POS_W : REF_BITS - 1) + 2;
  localparam int SQ_W   = 2 * DX_W + 8;
  localparam int SQ_IT  = SQ_W / 2;
  localparam int QB     = TRIG_W + 1;
  localparam int DIV_SHIFT = 19;
  localparam int D_W    = DX_W + 21;
  localparam int PROD_W = GRAD_BITS + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - TRIG_FRAC;
  localparam int SQR_W  = 2 * GRAD_BITS;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_COL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REF_ROW   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_MODE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_POST_MODE = CFG_IDX_W'(3);

  localparam logic PROJ_RADIAL = 1'b0;
  localparam int   POST_ABS_BIT = 0;
  localparam int   POST_SQR_BIT = 1;

  localparam logic [QB-1:0] TRIG_POS_LIMIT = QB'((1 << TRIG_FRAC) - 1);
  localparam logic [QB-1:0] TRIG_NEG_LIMIT = QB'(1 << TRIG_FRAC);
  localparam logic signed [TRIG_W-1:0] TRIG_MAX = TRIG_W'((1 << TRIG_FRAC) - 1);
  localparam logic signed [TRIG_W-1:0] TRIG_MIN = TRIG_W'(1 << TRIG_FRAC);

  localparam logic signed [SUM_W-1:0] RND_HALF    = SUM_W'(1 << (TRIG_FRAC - 1));
  localparam logic signed [SUM_W-1:0] RND_HALF_LO = SUM_W'((1 << (TRIG_FRAC - 1)) - 1);
  localparam logic signed [RND_W-1:0] RND_GMAX =
    (RND_W'(1) << (GRAD_BITS - 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] RND_GMIN = -(RND_W'(1) << (GRAD_BITS - 1));

  typedef struct packed {
    logic signed [GRAD_BITS-1:0] gx;
    logic signed [GRAD_BITS-1:0] gy;
    logic signed [DX_W-1:0]      dx;
    logic signed [DX_W-1:0]      dy;
    logic                        zero;
  } side_t;

endpackage

[hdl/rgp_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_channels
// Request channels of the projection block: samples in, results out and
// register writes.
// ----------------------------------------------------------------------------
interface rgp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [rgp_pkg::COORD_BITS-1:0]       pixel_col;
  logic [rgp_pkg::COORD_BITS-1:0]       pixel_row;
  logic signed [rgp_pkg::GRAD_BITS-1:0] grad_x;
  logic signed [rgp_pkg::GRAD_BITS-1:0] grad_y;
  modport source (output valid, pixel_col, pixel_row, grad_x, grad_y, input ready);
  modport sink (input valid, pixel_col, pixel_row, grad_x, grad_y, output ready);
endinterface

interface rgp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rgp_pkg::VALUE_W-1:0] value;
  logic                               saturated;
  modport source (output valid, value, saturated, input ready);
  modport sink (input valid, value, saturated, output ready);
endinterface

interface rgp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rgp_pkg::CFG_IDX_W-1:0]     index;
  logic [rgp_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/rgp_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rgp_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [rgp_pkg::SQ_W-1:0] num,
  input  rgp_pkg::side_t           in_side,
  output logic                     out_valid,
  output logic [rgp_pkg::SQ_IT-1:0] root,
  output rgp_pkg::side_t           out_side
);

  localparam int RW = rgp_pkg::SQ_W + 1;
  localparam int N  = rgp_pkg::SQ_IT;

  logic [RW-1:0]  num_d [N+1];
  logic [RW-1:0]  res_d [N+1];
  rgp_pkg::side_t side_d [N+1];
  logic [N:0]     vld_d;

  logic [RW-1:0]  num_q [N];
  logic [RW-1:0]  res_q [N];
  rgp_pkg::side_t side_q [N];
  logic [N-1:0]   vld_q;

  assign num_d[0]  = RW'(num);
  assign res_d[0]  = '0;
  assign side_d[0] = in_side;
  assign vld_d[0]  = in_valid;

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      localparam logic [RW-1:0] BIT = RW'(1) << (rgp_pkg::SQ_W - 2 - 2 * k);
      logic [RW-1:0] trial;
      logic [RW-1:0] num_next;
      logic [RW-1:0] res_next;

      always_comb begin
        trial = res_d[k] + BIT;
        if (num_d[k] >= trial) begin
          num_next = num_d[k] - trial;
          res_next = (res_d[k] >> 1) + BIT;
        end else begin
          num_next = num_d[k];
          res_next = res_d[k] >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld_q[k] <= 1'b0;
        end else if (en) begin
          vld_q[k] <= vld_d[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          num_q[k]  <= num_next;
          res_q[k]  <= res_next;
          side_q[k] <= side_d[k];
        end
      end

      assign num_d[k+1]  = num_q[k];
      assign res_d[k+1]  = res_q[k];
      assign side_d[k+1] = side_q[k];
      assign vld_d[k+1]  = vld_q[k];
    end
  endgenerate

  assign out_valid = vld_d[N];
  assign root      = res_d[N][N-1:0];
  assign out_side  = side_d[N];

endmodule

[hdl/rgp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_div
// Two-lane pipelined restoring divider forming the rounded magnitudes of
// cosine and sine, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [rgp_pkg::SQ_IT-1:0] root,
  input  rgp_pkg::side_t            in_side,
  output logic                      out_valid,
  output logic [rgp_pkg::QB-1:0]    quot_x,
  output logic [rgp_pkg::QB-1:0]    quot_y,
  output rgp_pkg::side_t            out_side
);

  localparam int DW = rgp_pkg::D_W;
  localparam int N  = rgp_pkg::QB;

  logic [DW-1:0]  rx_d [N+1];
  logic [DW-1:0]  ry_d [N+1];
  logic [N-1:0]   qx_d [N+1];
  logic [N-1:0]   qy_d [N+1];
  logic [DW-1:0]  dv_d [N+1];
  rgp_pkg::side_t side_d [N+1];
  logic [N:0]     vld_d;

  logic [DW-1:0]  rx_q [N+1];
  logic [DW-1:0]  ry_q [N+1];
  logic [N-1:0]   qx_q [N+1];
  logic [N-1:0]   qy_q [N+1];
  logic [DW-1:0]  dv_q [N+1];
  rgp_pkg::side_t side_q [N+1];
  logic [N:0]     vld_q;

  logic [rgp_pkg::DX_W-1:0] ax;
  logic [rgp_pkg::DX_W-1:0] ay;
  logic [DW-1:0]            half;

  always_comb begin
    ax   = in_side.dx[rgp_pkg::DX_W-1] ? rgp_pkg::DX_W'(-in_side.dx) : in_side.dx;
    ay   = in_side.dy[rgp_pkg::DX_W-1] ? rgp_pkg::DX_W'(-in_side.dy) : in_side.dy;
    half = DW'(root >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_q[0]   <= (DW'(ax) << rgp_pkg::DIV_SHIFT) + half;
      ry_q[0]   <= (DW'(ay) << rgp_pkg::DIV_SHIFT) + half;
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      dv_q[0]   <= DW'(root);
      side_q[0] <= in_side;
    end
  end

  genvar k;
  generate
    for (k = 0; k <= N; k++) begin : g_link
      assign rx_d[k]   = rx_q[k];
      assign ry_d[k]   = ry_q[k];
      assign qx_d[k]   = qx_q[k];
      assign qy_d[k]   = qy_q[k];
      assign dv_d[k]   = dv_q[k];
      assign side_d[k] = side_q[k];
      assign vld_d[k]  = vld_q[k];
    end

    for (k = 0; k < N; k++) begin : g_stage
      logic [DW-1:0] shifted;
      logic [DW-1:0] rx_next;
      logic [DW-1:0] ry_next;
      logic          bx;
      logic          by;

      always_comb begin
        shifted = dv_d[k] << (N - 1 - k);
        bx      = rx_d[k] >= shifted;
        by      = ry_d[k] >= shifted;
        rx_next = bx ? rx_d[k] - shifted : rx_d[k];
        ry_next = by ? ry_d[k] - shifted : ry_d[k];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld_q[k+1] <= 1'b0;
        end else if (en) begin
          vld_q[k+1] <= vld_d[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rx_q[k+1]   <= rx_next;
          ry_q[k+1]   <= ry_next;
          qx_q[k+1]   <= {qx_d[k][N-2:0], bx};
          qy_q[k+1]   <= {qy_d[k][N-2:0], by};
          dv_q[k+1]   <= dv_d[k];
          side_q[k+1] <= side_d[k];
        end
      end
    end
  endgenerate

  assign out_valid = vld_d[N];
  assign quot_x    = qx_d[N];
  assign quot_y    = qy_d[N];
  assign out_side  = side_d[N];

endmodule

[hdl/rgp_project.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_project
// Clamps cosine and sine, forms the radial or tangential projection, rounds
// and saturates it and applies the post step.
// ----------------------------------------------------------------------------
module rgp_project (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [rgp_pkg::QB-1:0]           quot_x,
  input  logic [rgp_pkg::QB-1:0]           quot_y,
  input  rgp_pkg::side_t                   in_side,
  input  logic                             projection_mode,
  input  logic [1:0]                       post_mode,
  output logic                             out_valid,
  output logic signed [rgp_pkg::VALUE_W-1:0] value,
  output logic                             saturated
);

  localparam int TW = rgp_pkg::TRIG_W;
  localparam int GB = rgp_pkg::GRAD_BITS;

  logic [4:0] vld;

  logic signed [TW-1:0]  ca;
  logic signed [TW-1:0]  sa;
  logic signed [GB-1:0]  gx1;
  logic signed [GB-1:0]  gy1;
  logic                  zero1;
  logic signed [rgp_pkg::PROD_W-1:0] m1;
  logic signed [rgp_pkg::PROD_W-1:0] m2;
  logic                  zero2;
  logic signed [rgp_pkg::SUM_W-1:0] sum;
  logic                  zero3;
  logic signed [GB-1:0]  res;
  logic                  sat4;
  logic                  zero4;

  logic signed [TW-1:0]  ca_next;
  logic signed [TW-1:0]  sa_next;
  logic signed [rgp_pkg::SUM_W-1:0] rnd_sum;
  logic signed [rgp_pkg::RND_W-1:0] rnd;
  logic signed [GB-1:0]  res_next;
  logic                  sat_next;
  logic signed [rgp_pkg::SQR_W-1:0] sq;
  logic signed [rgp_pkg::VALUE_W-1:0] wide;
  logic signed [rgp_pkg::VALUE_W-1:0] value_next;

  function automatic logic signed [rgp_pkg::TRIG_W-1:0] trig_clamp(
    input logic [rgp_pkg::QB-1:0] q, input logic neg);
    logic signed [rgp_pkg::TRIG_W-1:0] r;
    if (neg) begin
      if (q >= rgp_pkg::TRIG_NEG_LIMIT) begin
        r = rgp_pkg::TRIG_MIN;
      end else begin
        r = -$signed(rgp_pkg::TRIG_W'(q));
      end
    end else begin
      if (q > rgp_pkg::TRIG_POS_LIMIT) begin
        r = rgp_pkg::TRIG_MAX;
      end else begin
        r = $signed(rgp_pkg::TRIG_W'(q));
      end
    end
    return r;
  endfunction

  always_comb begin
    ca_next = trig_clamp(quot_x, in_side.dx[rgp_pkg::DX_W-1]);
    sa_next = trig_clamp(quot_y, in_side.dy[rgp_pkg::DX_W-1]);

    rnd_sum = sum + (sum[rgp_pkg::SUM_W-1] ? rgp_pkg::RND_HALF_LO : rgp_pkg::RND_HALF);
    rnd     = rgp_pkg::RND_W'(rnd_sum >>> rgp_pkg::TRIG_FRAC);
    if (rnd > rgp_pkg::RND_GMAX) begin
      res_next = GB'(rgp_pkg::RND_GMAX);
      sat_next = 1'b1;
    end else if (rnd < rgp_pkg::RND_GMIN) begin
      res_next = GB'(rgp_pkg::RND_GMIN);
      sat_next = 1'b1;
    end else begin
      res_next = GB'(rnd);
      sat_next = 1'b0;
    end

    sq   = res * res;
    wide = rgp_pkg::VALUE_W'(res);
    if (zero4) begin
      value_next = '0;
    end else if (post_mode[rgp_pkg::POST_SQR_BIT]) begin
      value_next = rgp_pkg::VALUE_W'(sq);
    end else if (post_mode[rgp_pkg::POST_ABS_BIT] && wide[rgp_pkg::VALUE_W-1]) begin
      value_next = -wide;
    end else begin
      value_next = wide;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca    <= ca_next;
      sa    <= sa_next;
      gx1   <= in_side.gx;
      gy1   <= in_side.gy;
      zero1 <= in_side.zero;

      if (projection_mode == rgp_pkg::PROJ_RADIAL) begin
        m1 <= gx1 * ca;
        m2 <= gy1 * sa;
      end else begin
        m1 <= gx1 * sa;
        m2 <= gy1 * ca;
      end
      zero2 <= zero1;

      if (projection_mode == rgp_pkg::PROJ_RADIAL) begin
        sum <= rgp_pkg::SUM_W'(m1) + rgp_pkg::SUM_W'(m2);
      end else begin
        sum <= rgp_pkg::SUM_W'(m1) - rgp_pkg::SUM_W'(m2);
      end
      zero3 <= zero2;

      res   <= res_next;
      sat4  <= sat_next;
      zero4 <= zero3;

      value     <= value_next;
      saturated <= sat4 && !zero4;
    end
  end

  assign out_valid = vld[4];

endmodule

[hdl/radial_gradient_projection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_gradient_projection
// Projects gradient samples onto the radial or tangential direction seen
// from a configured reference point.
// ----------------------------------------------------------------------------
// Channel  Role  Payload
// sample   sink  pixel_col, pixel_row, grad_x, grad_y
// result   src   value, saturated
// cfg      sink  index, data (register write, always ready)
//
// One request per cycle is accepted unless the result channel stalls.
// Reset clears all valid bits and the configuration registers.
// A stall of the result channel freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module radial_gradient_projection (
  input  logic       clk,
  input  logic       rst,
  rgp_in_if.sink     sample,
  rgp_out_if.source  result,
  rgp_cfg_if.sink    cfg
);

  localparam int DXW = rgp_pkg::DX_W;

  logic signed [rgp_pkg::REF_BITS-1:0] ref_col;
  logic signed [rgp_pkg::REF_BITS-1:0] ref_row;
  logic                                projection_mode;
  logic [1:0]                          post_mode;

  logic en;
  logic v1, v2, v3;
  logic signed [DXW-1:0] dx1, dy1;
  logic signed [rgp_pkg::GRAD_BITS-1:0] gx1, gy1;
  logic signed [2*DXW-1:0] sx2, sy2;
  rgp_pkg::side_t side2, side3;
  logic [rgp_pkg::SQ_W-1:0] num3;

  logic                       sq_valid;
  logic [rgp_pkg::SQ_IT-1:0]  sq_root;
  rgp_pkg::side_t             sq_side;
  logic                       dv_valid;
  logic [rgp_pkg::QB-1:0]     quot_x;
  logic [rgp_pkg::QB-1:0]     quot_y;
  rgp_pkg::side_t             dv_side;
  logic                       pr_valid;

  assign en           = !pr_valid || result.ready;
  assign sample.ready = en;
  assign cfg.ready    = 1'b1;
  assign result.valid = pr_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_col         <= '0;
      ref_row         <= '0;
      projection_mode <= 1'b0;
      post_mode       <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        rgp_pkg::CFG_REF_COL:   ref_col <= cfg.data[rgp_pkg::REF_BITS-1:0];
        rgp_pkg::CFG_REF_ROW:   ref_row <= cfg.data[rgp_pkg::REF_BITS-1:0];
        rgp_pkg::CFG_PROJ_MODE: projection_mode <= cfg.data[0];
        rgp_pkg::CFG_POST_MODE: post_mode <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= sample.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= DXW'($signed({1'b0, sample.pixel_col, {rgp_pkg::REF_FRAC{1'b0}}}))
             - DXW'(ref_col);
      dy1 <= DXW'($signed({1'b0, sample.pixel_row, {rgp_pkg::REF_FRAC{1'b0}}}))
             - DXW'(ref_row);
      gx1 <= sample.grad_x;
      gy1 <= sample.grad_y;

      sx2        <= dx1 * dx1;
      sy2        <= dy1 * dy1;
      side2.gx   <= gx1;
      side2.gy   <= gy1;
      side2.dx   <= dx1;
      side2.dy   <= dy1;
      side2.zero <= (dx1 == '0) && (dy1 == '0);

      num3  <= (rgp_pkg::SQ_W'($unsigned(sx2)) + rgp_pkg::SQ_W'($unsigned(sy2))) << 8;
      side3 <= side2;
    end
  end

  rgp_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .num      (num3),
    .in_side  (side3),
    .out_valid(sq_valid),
    .root     (sq_root),
    .out_side (sq_side)
  );

  rgp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sq_valid),
    .root     (sq_root),
    .in_side  (sq_side),
    .out_valid(dv_valid),
    .quot_x   (quot_x),
    .quot_y   (quot_y),
    .out_side (dv_side)
  );

  rgp_project u_project (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (dv_valid),
    .quot_x         (quot_x),
    .quot_y         (quot_y),
    .in_side        (dv_side),
    .projection_mode(projection_mode),
    .post_mode      (post_mode),
    .out_valid      (pr_valid),
    .value          (result.value),
    .saturated      (result.saturated)
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radial and tangential gradient projection.
// Samples are sent through a table of directed requests and then phases of
// random requests, each phase under its own reference point and modes.
// A bit-exact predictor works out results the table does not give; all are
// compared in order, both channels idling in random bursts but in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
  import rgp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(200);
  localparam logic [1:0] POST_NONE = 2'd0;
  localparam logic [1:0] POST_ABS  = 2'd1;
  localparam logic [1:0] POST_SQR  = 2'd2;
  localparam logic [1:0] POST_BOTH = 2'd3;
  localparam logic PROJ_TANGENT = 1'b1;
  localparam longint GMAX = (64'sd1 <<< (GRAD_BITS - 1)) - 1;
  localparam longint GMIN = -GMAX - 1;
  localparam int SETTLE = 60;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;
  } projection_t;

  typedef struct {
    int     col;
    int     row;
    longint gx;
    longint gy;
    bit     typed;
    longint value;
    bit     saturated;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rgp_in_if  smp ();
  rgp_out_if res ();
  rgp_cfg_if cfg_ch ();

  radial_gradient_projection dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longint      ref_col_q;
  longint      ref_row_q;
  logic        proj_q;
  logic [1:0]  post_q;
  projection_t pending_projections[$];
  int          failures = 0;
  int          requests_sent = 0;
  int          results_checked = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  int          stall_left = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint div_nearest(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clip_trig(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic projection_t project(int col, int row, longint gx, longint gy);
    projection_t p;
    longint dx, dy, rad, cs, sn, sum, val;
    longint unsigned sq;
    p.value = '0;
    p.saturated = 1'b0;
    dx = longint'(col) * 16 - ref_col_q;
    dy = longint'(row) * 16 - ref_row_q;
    if (dx == 0 && dy == 0) return p;
    sq = dx * dx + dy * dy;
    rad = int_sqrt(sq << 8);
    cs = clip_trig(div_nearest(dx * 524288, rad));
    sn = clip_trig(div_nearest(dy * 524288, rad));
    if (proj_q == PROJ_RADIAL) sum = gx * cs + gy * sn;
    else sum = gx * sn - gy * cs;
    val = div_nearest(sum, 64'sd1 <<< TRIG_FRAC);
    if (val > GMAX) begin
      val = GMAX;
      p.saturated = 1'b1;
    end else if (val < GMIN) begin
      val = GMIN;
      p.saturated = 1'b1;
    end
    if (post_q[POST_SQR_BIT]) val = val * val;
    else if (post_q[POST_ABS_BIT] && val < 0) val = -val;
    p.value = val[VALUE_W-1:0];
    return p;
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    logic signed [REF_BITS-1:0] r;
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    r = val[REF_BITS-1:0];
    case (idx)
      CFG_REF_COL: ref_col_q = r;
      CFG_REF_ROW: ref_row_q = r;
      CFG_PROJ_MODE: proj_q = val[0];
      CFG_POST_MODE: post_q = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic configure(longint rc, longint rr, logic pm, logic [1:0] po);
    logic [31:0] junk;
    junk = $urandom;
    write_register(CFG_REF_COL, {junk[31:REF_BITS], rc[REF_BITS-1:0]});
    junk = $urandom;
    write_register(CFG_REF_ROW, {junk[31:REF_BITS], rr[REF_BITS-1:0]});
    junk = $urandom;
    write_register(CFG_PROJ_MODE, {junk[31:1], pm});
    junk = $urandom;
    write_register(CFG_POST_MODE, {junk[31:2], po});
    write_register(CFG_UNUSED, $urandom);
  endtask

  task automatic drain();
    while (pending_projections.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_sample(sample_row_t s);
    projection_t p;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      smp.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    smp.valid = 1'b1;
    smp.pixel_col = s.col[COORD_BITS-1:0];
    smp.pixel_row = s.row[COORD_BITS-1:0];
    smp.grad_x = s.gx[GRAD_BITS-1:0];
    smp.grad_y = s.gy[GRAD_BITS-1:0];
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    if (s.typed) begin
      p.value = s.value[VALUE_W-1:0];
      p.saturated = s.saturated;
    end else begin
      p = project(s.col, s.row, s.gx, s.gy);
    end
    pending_projections.push_back(p);
    requests_sent++;
  endtask

  function automatic sample_row_t random_sample();
    sample_row_t s;
    s.typed = 1'b0;
    s.value = 0;
    s.saturated = 1'b0;
    s.col = $urandom_range(0, 4095);
    s.row = $urandom_range(0, 4095);
    if ($urandom_range(0, 9) == 0 && ref_col_q % 16 == 0 && ref_row_q % 16 == 0 &&
        ref_col_q >= 0 && ref_row_q >= 0 && ref_col_q < 65536 && ref_row_q < 65536) begin
      s.col = int'(ref_col_q / 16);
      s.row = int'(ref_row_q / 16);
    end else if ($urandom_range(0, 3) == 0 && ref_col_q >= 0 && ref_row_q >= 0 &&
                 ref_col_q < 65536 && ref_row_q < 65536) begin
      s.col = int'(ref_col_q / 16) + $urandom_range(0, 2);
      s.row = int'(ref_row_q / 16) + $urandom_range(0, 2);
      if (s.col > 4095) s.col = 4095;
      if (s.row > 4095) s.row = 4095;
    end
    if ($urandom_range(0, 3) == 0) begin
      s.gx = $signed($urandom_range(0, 2047)) - 1024;
      s.gy = $signed($urandom_range(0, 2047)) - 1024;
    end else begin
      s.gx = longint'($urandom_range(0, 1048575)) - 524288;
      s.gy = longint'($urandom_range(0, 1048575)) - 524288;
    end
    return s;
  endfunction

  always @(negedge clk) begin
    if (quiet) begin
      res.ready = 1'b1;
    end else if (stall_left > 0) begin
      res.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      res.ready = 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      res.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    projection_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_projections.size() == 0) begin
        $error("unexpected result value %0d saturated %0d", res.value, res.saturated);
        failures++;
      end else begin
        want = pending_projections.pop_front();
        results_checked++;
        if (res.value !== want.value) begin
          $error("value expected %0d actual %0d", want.value, res.value);
          failures++;
        end
        if (res.saturated !== want.saturated) begin
          $error("saturated expected %0d actual %0d", want.saturated, res.saturated);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  sample_row_t directed[] = '{
    '{0, 0, 0, 0, 1'b1, 0, 1'b0},
    '{0, 0, 524287, 524287, 1'b1, 0, 1'b0},
    '{0, 0, -524288, -524288, 1'b1, 0, 1'b0},
    '{0, 0, 524287, -524288, 1'b1, 0, 1'b0},
    '{1, 1, 524287, 524287, 1'b0, 0, 1'b0},
    '{1, 1, -524288, -524288, 1'b0, 0, 1'b0},
    '{1, 1, 524287, -524288, 1'b0, 0, 1'b0},
    '{4095, 4095, 524287, 524287, 1'b0, 0, 1'b0},
    '{4095, 4095, -524288, 524287, 1'b0, 0, 1'b0},
    '{4095, 0, 524287, 0, 1'b0, 0, 1'b0},
    '{4095, 0, -524288, 0, 1'b0, 0, 1'b0},
    '{0, 4095, 0, 524287, 1'b0, 0, 1'b0},
    '{0, 4095, 0, -524288, 1'b0, 0, 1'b0},
    '{1, 0, 256, 256, 1'b0, 0, 1'b0},
    '{0, 1, -256, 256, 1'b0, 0, 1'b0},
    '{3, 4, 1, -1, 1'b0, 0, 1'b0},
    '{4095, 1, 128, -128, 1'b0, 0, 1'b0},
    '{1, 4095, -1, 0, 1'b0, 0, 1'b0},
    '{2048, 2048, 0, 0, 1'b0, 0, 1'b0},
    '{1234, 3210, -1, -1, 1'b0, 0, 1'b0}
  };

  initial begin
    smp.valid = 1'b0;
    smp.pixel_col = '0;
    smp.pixel_row = '0;
    smp.grad_x = '0;
    smp.grad_y = '0;
    res.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    ref_col_q = 0;
    ref_row_q = 0;
    proj_q = PROJ_RADIAL;
    post_q = POST_NONE;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_sample(directed[i]);
    @(negedge clk);
    smp.valid = 1'b0;
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: configure(-65536, -65536, PROJ_RADIAL, POST_ABS);
        1: configure(65535, 65535, PROJ_TANGENT, POST_NONE);
        2: configure(32768, 16384, PROJ_RADIAL, POST_SQR);
        3: configure(1000, -7, PROJ_TANGENT, POST_BOTH);
        4: configure(-65536, 65535, PROJ_TANGENT, POST_ABS);
        5: configure(1600, 800, PROJ_RADIAL, POST_NONE);
        default: begin
          quiet = 1'b1;
          configure(0, 0, PROJ_TANGENT, POST_SQR);
        end
      endcase
      repeat (70) send_sample(random_sample());
      @(negedge clk);
      smp.valid = 1'b0;
      drain();
    end

    $display("Sent %0d sample requests and checked %0d results", requests_sent,
             results_checked);
    $display("across eight register settings with both projections and all post modes.");
    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rgp_pkg.sv
hdl/rgp_channels.sv
hdl/rgp_sqrt.sv
hdl/rgp_div.sv
hdl/rgp_project.sv
hdl/radial_gradient_projection.sv
sim/tb_top.sv
